// ===== src/lenns_pkg.sv =====
// Package: constants, byte codes and shared types for the line ending normalizer.
`default_nettype none
package lenns_pkg;

    localparam int unsigned LINE_LIMIT = 65536;
    localparam int unsigned SEG_W      = $clog2(LINE_LIMIT + 1);

    localparam logic [7:0] CH_EOF = 8'h1A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_D0  = 8'h30;
    localparam logic [7:0] CH_D9  = 8'h39;

    localparam logic [1:0] PH_SPACES = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_REST   = 2'd2;

    // result buffer depth; must hold two results beyond one in flight
    localparam int unsigned RBUF_DEPTH = 4;
    localparam int unsigned RBUF_AW    = $clog2(RBUF_DEPTH);
    localparam int unsigned RBUF_CW    = $clog2(RBUF_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       stream_done;
        logic       last_of_run;
    } t_result;

    // results produced by one item, written to the buffer in the same cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage : lenns_pkg
`default_nettype wire

// ===== src/lenns_if.sv =====
// Interfaces: input byte channel and result channel with valid/ready handshake.
`default_nettype none
interface lenns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_item;

    modport source (output valid, output data_byte, output end_item, input ready);
    modport sink   (input valid, input data_byte, input end_item, output ready);
endinterface : lenns_in_if

interface lenns_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_done;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_valid,
                    output stream_done, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input stream_done, input last_of_run, output ready);
endinterface : lenns_out_if
`default_nettype wire

// ===== src/lenns_core.sv =====
// Core: input register, line state and the per-byte normalizing decision.
`default_nettype none
module lenns_core
    import lenns_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    output logic            o_in_ready,
    input  wire logic       i_space_ok,
    output t_push           o_push
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;

    logic             r_cr_pending;
    logic [1:0]       r_phase;
    logic [SEG_W-1:0] r_seg_len;
    logic             r_stopped;

    logic             n_cr_pending;
    logic [1:0]       n_phase;
    logic [SEG_W-1:0] n_seg_len;
    logic             n_stopped;

    logic             w_fire;
    logic             w_in_acc;
    logic             w_digit;
    t_result          w_res [2];
    logic [1:0]       w_cnt;
    t_push            w_push;

    assign w_fire     = r_in_valid && i_space_ok;
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_digit    = (r_in_byte >= CH_D0) && (r_in_byte <= CH_D9);

    always_comb begin
        t_result lf_res;
        t_result done_res;
        t_result sp_res;
        t_result ch_res;
        logic    finished;

        lf_res   = '{out_byte: CH_LF, byte_valid: 1'b1, stream_done: 1'b0, last_of_run: 1'b0};
        done_res = '{out_byte: 8'h00, byte_valid: 1'b0, stream_done: 1'b1, last_of_run: 1'b0};
        sp_res   = '{out_byte: CH_SP, byte_valid: 1'b1, stream_done: 1'b0, last_of_run: 1'b0};
        ch_res   = '{out_byte: r_in_byte, byte_valid: 1'b1, stream_done: 1'b0,
                     last_of_run: 1'b0};
        finished = 1'b0;

        n_cr_pending = r_cr_pending;
        n_phase      = r_phase;
        n_seg_len    = r_seg_len;
        n_stopped    = r_stopped;
        w_res[0]     = done_res;
        w_res[1]     = done_res;
        w_cnt        = 2'd0;

        if (r_stopped) begin
            // drop bytes until an end item, which restores reset state
            if (r_in_end) begin
                n_stopped = 1'b0;
            end
        end else if (r_in_end || r_in_byte == CH_EOF) begin
            if (r_cr_pending) begin
                w_res[w_cnt[0]] = lf_res;
                w_cnt           = w_cnt + 2'd1;
            end
            w_res[w_cnt[0]] = done_res;
            w_cnt           = w_cnt + 2'd1;
            n_cr_pending    = 1'b0;
            n_phase         = PH_SPACES;
            n_seg_len       = '0;
            n_stopped       = !r_in_end;
        end else begin
            if (r_cr_pending) begin
                n_cr_pending    = 1'b0;
                w_res[w_cnt[0]] = lf_res;
                w_cnt           = w_cnt + 2'd1;
                n_phase         = PH_SPACES;
                n_seg_len       = '0;
                // CR LF pair collapses to the LF already emitted
                if (r_in_byte == CH_LF) begin
                    finished = 1'b1;
                end
            end
            if (!finished) begin
                if (r_in_byte == CH_CR) begin
                    n_cr_pending = 1'b1;
                end else if (r_in_byte == CH_LF) begin
                    w_res[w_cnt[0]] = lf_res;
                    w_cnt           = w_cnt + 2'd1;
                    n_phase         = PH_SPACES;
                    n_seg_len       = '0;
                end else begin
                    // full segment: restart line-start handling without a newline
                    if (n_seg_len >= SEG_W'(LINE_LIMIT)) begin
                        n_phase   = PH_SPACES;
                        n_seg_len = '0;
                    end
                    n_seg_len = n_seg_len + SEG_W'(1);
                    case (n_phase)
                        PH_SPACES: begin
                            if (w_digit) begin
                                n_phase = PH_DIGITS;
                            end else if (r_in_byte != CH_SP) begin
                                n_phase = PH_REST;
                            end
                        end
                        PH_DIGITS: begin
                            if (!w_digit) begin
                                if (r_in_byte != CH_SP && r_in_byte != CH_TAB) begin
                                    w_res[w_cnt[0]] = sp_res;
                                    w_cnt           = w_cnt + 2'd1;
                                end
                                n_phase = PH_REST;
                            end
                        end
                        default: begin
                        end
                    endcase
                    w_res[w_cnt[0]] = ch_res;
                    w_cnt           = w_cnt + 2'd1;
                end
            end
        end

        if (w_cnt == 2'd1) begin
            w_res[0].last_of_run = 1'b1;
        end else if (w_cnt == 2'd2) begin
            w_res[1].last_of_run = 1'b1;
        end
    end

    always_comb begin
        w_push.count = w_fire ? w_cnt : 2'd0;
        w_push.res0  = w_res[0];
        w_push.res1  = w_res[1];
    end
    assign o_push = w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_end  <= i_in_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_pending <= 1'b0;
            r_phase      <= PH_SPACES;
            r_seg_len    <= '0;
            r_stopped    <= 1'b0;
        end else if (w_fire) begin
            r_cr_pending <= n_cr_pending;
            r_phase      <= n_phase;
            r_seg_len    <= n_seg_len;
            r_stopped    <= n_stopped;
        end
    end

`ifndef ASSERT_OFF
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_len <= SEG_W'(LINE_LIMIT))
        else $error("segment length beyond limit");
    a_stop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (!r_cr_pending && r_seg_len == '0))
        else $error("stopped with live line state");
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_stopped) |-> (w_push.count == 2'd0))
        else $error("result produced while stopped");
`endif

endmodule : lenns_core
`default_nettype wire

// ===== src/lenns_rbuf.sv =====
// Result buffer: two results in a cycle at most; one out a cycle while ready.
`default_nettype none
module lenns_rbuf
    import lenns_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_space_ok,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_res
);

    t_result            r_mem [RBUF_DEPTH];
    logic [RBUF_AW-1:0] r_wr_ptr;
    logic [RBUF_AW-1:0] r_rd_ptr;
    logic [RBUF_CW-1:0] r_count;
    logic [RBUF_CW-1:0] n_count;
    logic               w_pop;
    logic [RBUF_AW-1:0] w_wr_ptr1;

    assign o_valid    = (r_count != '0);
    assign o_space_ok = (r_count <= RBUF_CW'(RBUF_DEPTH - 2));
    assign w_pop      = o_valid && i_ready;
    assign o_res      = r_mem[r_rd_ptr];
    assign w_wr_ptr1  = r_wr_ptr + RBUF_AW'(1);
    assign n_count    = r_count + RBUF_CW'(i_push.count) - RBUF_CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RBUF_AW'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + RBUF_AW'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_space_ok)
        else $error("push into full result buffer");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RBUF_CW'(RBUF_DEPTH))
        else $error("result buffer count out of range");
`endif

endmodule : lenns_rbuf
`default_nettype wire

// ===== src/line_ending_normalizer_with_number_space.sv =====
// Top level: line ending normalizer with a space after leading line numbers.
// One input beat is taken per cycle while the result buffer has room for two results; each
// byte gives zero, one or two result beats, and the result channel sends one beat a cycle
// while the receiver is ready, so the sustained rate is set by the result port; an item
// that emits a CR-flushed LF or an inserted space can give two beats. An input beat
// passes the input register, then the result buffer, before its first result beat. CR,
// LF and CRLF become one LF; 0x1A or an end item closes the stream with an end-marker beat.
`default_nettype none
module line_ending_normalizer_with_number_space
    import lenns_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lenns_in_if.sink    i_in,
    lenns_out_if.source o_out
);

    logic    w_space_ok;
    t_push   w_push;
    t_result w_res;

    lenns_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_byte  (i_in.data_byte),
        .i_in_end   (i_in.end_item),
        .o_in_ready (i_in.ready),
        .i_space_ok (w_space_ok),
        .o_push     (w_push)
    );

    lenns_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space_ok (w_space_ok),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (w_res)
    );

    assign o_out.out_byte    = w_res.out_byte;
    assign o_out.byte_valid  = w_res.byte_valid;
    assign o_out.stream_done = w_res.stream_done;
    assign o_out.last_of_run = w_res.last_of_run;

`ifndef ASSERT_OFF
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_done) |-> (o_out.last_of_run && !o_out.byte_valid))
        else $error("end marker beat malformed");
`endif

endmodule : line_ending_normalizer_with_number_space
`default_nettype wire
